FILE: rtl/dtq_pkg.sv
// Package for the deadline timer queue: beat types, action and status codes,
// and the command and status bundles between controller and datapath. No dependencies.
`default_nettype none

package dtq_pkg;

   localparam logic [2:0] ACT_ADD    = 3'd0;
   localparam logic [2:0] ACT_DELETE = 3'd1;
   localparam logic [2:0] ACT_EXPIRE = 3'd2;
   localparam logic [2:0] ACT_QUERY  = 3'd3;
   localparam logic [2:0] ACT_CLEAR  = 3'd4;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_EXISTS    = 3'd1;
   localparam logic [2:0] ST_NO_REF    = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_NONE_DUE  = 3'd4;
   localparam logic [2:0] ST_EXHAUSTED = 3'd5;

   localparam logic [7:0] IdleReset = 8'd70;
   localparam int MaxResults = 16;
   localparam int ExpWidth = $clog2(MaxResults);

   typedef struct packed {
      logic [2:0]  action;
      logic [31:0] now;
      logic [31:0] delay;
      logic [31:0] ref_number;
      logic [15:0] payload;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] ref_out;
      logic [15:0] payload_out;
      logic [31:0] timeout;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic rotate;
      logic finish;
      logic pop;
      logic pop_last;
      logic none_due;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic scan_end;
      logic head_due;
      logic next_due;
      logic out_free;
   } stat_type;

endpackage

`default_nettype wire

FILE: rtl/dtq_ctrl.sv
// Controller of the deadline timer queue: sequences scan, finish and expire steps.
// Depends on dtq_pkg.
`default_nettype none

module dtq_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic [2:0]       req_action,
   input  wire dtq_pkg::stat_type stat,
   output dtq_pkg::cmd_type      cmd,
   output logic                  req_stall
);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH, S_EXPIRE} state_type;

   state_type                     state_ff, state_in;
   logic [dtq_pkg::ExpWidth-1:0]  exp_ff, exp_in;
   logic                          stall_ff, stall_in;

   always_comb begin
      state_in = state_ff;
      exp_in = exp_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               exp_in = '0;
               case (req_action)
                  dtq_pkg::ACT_ADD, dtq_pkg::ACT_DELETE: begin
                     state_in = stat.count_zero ? S_FINISH : S_SCAN;
                  end
                  dtq_pkg::ACT_EXPIRE: state_in = S_EXPIRE;
                  dtq_pkg::ACT_QUERY, dtq_pkg::ACT_CLEAR: state_in = S_FINISH;
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_SCAN: begin
            cmd.rotate = 1'b1;
            if (stat.scan_end) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_EXPIRE: begin
            if (stat.out_free) begin
               if (stat.head_due) begin
                  cmd.pop = 1'b1;
                  cmd.pop_last = (exp_ff == dtq_pkg::ExpWidth'(dtq_pkg::MaxResults - 1))
                                 || !stat.next_due;
                  exp_in = exp_ff + 1'b1;
                  if (cmd.pop_last) begin
                     state_in = S_IDLE;
                  end
               end else begin
                  cmd.none_due = 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
      stall_in = (state_in != S_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         exp_ff <= '0;
         stall_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         exp_ff <= exp_in;
         stall_ff <= stall_in;
      end
   end

   assign req_stall = stall_ff;

endmodule

`default_nettype wire

FILE: rtl/dtq_dp.sv
// Datapath of the deadline timer queue: sorted timer cells, scan registers,
// result register and the idle timeout register. Depends on dtq_pkg.
`default_nettype none

module dtq_dp #(
   parameter int DEPTH = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire dtq_pkg::req_type req_data,
   input  wire dtq_pkg::cmd_type cmd,
   output dtq_pkg::stat_type     stat,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output dtq_pkg::rsp_type      rsp_data,
   input  wire logic             csr_write_enable,
   input  wire logic [7:0]       csr_write_data
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NextIdx = (DEPTH > 1) ? 1 : 0;

   logic [31:0] dl_ff [DEPTH];
   logic [31:0] dl_in [DEPTH];
   logic [31:0] ref_ff [DEPTH];
   logic [31:0] ref_in [DEPTH];
   logic [15:0] pay_ff [DEPTH];
   logic [15:0] pay_in [DEPTH];
   logic [DEPTH-1:0] le;

   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    scan_ff, scan_in;
   logic             found_ff, found_in;
   logic [IW-1:0]    idx_ff, idx_in;
   logic [31:0]      max_ff, max_in;
   dtq_pkg::req_type item_ff, item_in;
   logic [31:0]      due_ff, due_in;
   logic [7:0]       idle_ff, idle_in;
   dtq_pkg::rsp_type rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [32:0]   sum;
   logic          do_insert, do_remove, emit;
   logic [IW-1:0] rm_idx;
   logic [31:0]   got_ref;

   assign sum = {1'b0, req_data.now} + {1'b0, req_data.delay};
   assign got_ref = (item_ff.ref_number == 32'd0) ? (max_ff + 32'd1) : item_ff.ref_number;

   always_comb begin
      item_in = item_ff;
      due_in = due_ff;
      scan_in = scan_ff;
      found_in = found_ff;
      idx_in = idx_ff;
      max_in = max_ff;
      count_in = count_ff;
      rsp_in = rsp_ff;
      emit = 1'b0;
      do_insert = 1'b0;
      do_remove = 1'b0;
      rm_idx = '0;
      idle_in = csr_write_enable ? csr_write_data : idle_ff;
      if (cmd.load) begin
         item_in = req_data;
         due_in = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
         scan_in = '0;
         found_in = 1'b0;
         idx_in = '0;
         max_in = '0;
      end
      if (cmd.rotate) begin
         scan_in = scan_ff + 1'b1;
         if (ref_ff[0] > max_ff) begin
            max_in = ref_ff[0];
         end
         if (item_ff.ref_number != 32'd0 && ref_ff[0] == item_ff.ref_number) begin
            found_in = 1'b1;
            idx_in = scan_ff[IW-1:0];
         end
      end
      if (cmd.finish) begin
         rsp_in = '0;
         rsp_in.last = 1'b1;
         emit = 1'b1;
         case (item_ff.action)
            dtq_pkg::ACT_ADD: begin
               if (item_ff.ref_number == 32'd0 && max_ff == 32'hFFFF_FFFF) begin
                  rsp_in.status = dtq_pkg::ST_EXHAUSTED;
               end else if (item_ff.ref_number != 32'd0 && found_ff) begin
                  rsp_in.status = dtq_pkg::ST_EXISTS;
               end else if (count_ff == CW'(DEPTH)) begin
                  rsp_in.status = dtq_pkg::ST_FULL;
               end else begin
                  rsp_in.status = dtq_pkg::ST_OK;
                  rsp_in.ref_out = got_ref;
                  do_insert = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            dtq_pkg::ACT_DELETE: begin
               if (found_ff) begin
                  rsp_in.status = dtq_pkg::ST_OK;
                  rsp_in.ref_out = item_ff.ref_number;
                  do_remove = 1'b1;
                  rm_idx = idx_ff;
                  count_in = count_ff - 1'b1;
               end else begin
                  rsp_in.status = dtq_pkg::ST_NO_REF;
               end
            end
            dtq_pkg::ACT_QUERY: begin
               if (count_ff == '0) begin
                  rsp_in.timeout = {24'd0, idle_ff};
               end else if (dl_ff[0] > item_ff.now) begin
                  rsp_in.timeout = dl_ff[0] - item_ff.now;
               end
            end
            dtq_pkg::ACT_CLEAR: count_in = '0;
            default: emit = 1'b0;
         endcase
      end
      if (cmd.pop) begin
         rsp_in = '0;
         rsp_in.status = dtq_pkg::ST_OK;
         rsp_in.ref_out = ref_ff[0];
         rsp_in.payload_out = pay_ff[0];
         rsp_in.last = cmd.pop_last;
         emit = 1'b1;
         do_remove = 1'b1;
         count_in = count_ff - 1'b1;
      end
      if (cmd.none_due) begin
         rsp_in = '0;
         rsp_in.status = dtq_pkg::ST_NONE_DUE;
         rsp_in.last = 1'b1;
         emit = 1'b1;
      end
      rsp_valid_in = emit ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam int UpIdx = (i < DEPTH - 1) ? i + 1 : i;
      localparam int DnIdx = (i > 0) ? i - 1 : 0;
      localparam logic [CW-1:0] Pos = CW'(i);
      localparam logic [CW-1:0] PosUp = CW'(i + 1);
      localparam logic [CW-1:0] PosDn = CW'(DnIdx);
      localparam logic [IW-1:0] PosIdx = IW'(i);

      logic before_le;

      assign le[i] = dl_ff[i] <= due_ff;
      assign before_le = (i == 0) ? 1'b1 : (le[DnIdx] && PosDn < count_ff);

      always_comb begin
         dl_in[i] = dl_ff[i];
         ref_in[i] = ref_ff[i];
         pay_in[i] = pay_ff[i];
         if (cmd.rotate) begin
            if (PosUp < count_ff) begin
               dl_in[i] = dl_ff[UpIdx];
               ref_in[i] = ref_ff[UpIdx];
               pay_in[i] = pay_ff[UpIdx];
            end else begin
               dl_in[i] = dl_ff[0];
               ref_in[i] = ref_ff[0];
               pay_in[i] = pay_ff[0];
            end
         end else if (do_remove) begin
            if (PosIdx >= rm_idx) begin
               dl_in[i] = dl_ff[UpIdx];
               ref_in[i] = ref_ff[UpIdx];
               pay_in[i] = pay_ff[UpIdx];
            end
         end else if (do_insert) begin
            if (Pos < count_ff && le[i]) begin
               dl_in[i] = dl_ff[i];
            end else if (before_le) begin
               dl_in[i] = due_ff;
               ref_in[i] = got_ref;
               pay_in[i] = item_ff.payload;
            end else begin
               dl_in[i] = dl_ff[DnIdx];
               ref_in[i] = ref_ff[DnIdx];
               pay_in[i] = pay_ff[DnIdx];
            end
         end
      end

      always_ff @(posedge clock) begin
         dl_ff[i] <= dl_in[i];
         ref_ff[i] <= ref_in[i];
         pay_ff[i] <= pay_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         idle_ff <= dtq_pkg::IdleReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         idle_ff <= idle_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff <= item_in;
      due_ff <= due_in;
      scan_ff <= scan_in;
      found_ff <= found_in;
      idx_ff <= idx_in;
      max_ff <= max_in;
      rsp_ff <= rsp_in;
   end

   assign stat.count_zero = (count_ff == '0);
   assign stat.scan_end = (scan_ff == count_ff - 1'b1);
   assign stat.head_due = (count_ff != '0) && (dl_ff[0] <= item_ff.now);
   assign stat.next_due = (count_ff > CW'(1)) && (dl_ff[NextIdx] <= item_ff.now);
   assign stat.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

FILE: rtl/deadline_timer_queue.sv
// Top level of the deadline timer queue: joins controller and datapath.
// Depends on dtq_pkg, dtq_ctrl and dtq_dp.
//
//   port group   direction  beat
//   req_         in         one action with time, delay, reference, payload
//   rsp_         out        one result; last marks the final beat of an action
//   csr_         in         write of the idle timeout
//
// Add and delete rotate the table once through its head cell to find duplicates,
// the largest reference and the delete slot.
// Query and clear go straight to the finish step; expire pops one due timer per cycle
// while the result is not stalled, or answers none due when nothing is due.
// Reset is synchronous and empties the table; no clearing pass is needed.
// A stalled result holds; the next action waits until its first beat can be loaded.
`default_nettype none

module deadline_timer_queue #(
   parameter int DEPTH = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire dtq_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output dtq_pkg::rsp_type      rsp_data,
   input  wire logic             csr_write_enable,
   input  wire logic [7:0]       csr_write_data
);

   dtq_pkg::cmd_type  cmd;
   dtq_pkg::stat_type stat;

   dtq_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_action(req_data.action),
      .stat(stat),
      .cmd(cmd),
      .req_stall(req_stall)
   );

   dtq_dp #(.DEPTH(DEPTH)) u_dp (
      .clock(clock),
      .reset(reset),
      .req_data(req_data),
      .cmd(cmd),
      .stat(stat),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

endmodule

`default_nettype wire

FILE: rtl/dtq_checker.sv
// Port checker for the deadline timer queue, bound to the top level.
// Depends on dtq_pkg and deadline_timer_queue.
`default_nettype none

module dtq_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire dtq_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire dtq_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("Stalled result beat changed.");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("Result or stall present after reset.");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= dtq_pkg::ST_EXHAUSTED)
      else $error("Undefined status code.");

   a_error_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != dtq_pkg::ST_OK |-> rsp_data.last)
      else $error("Failed action did not end with its only beat.");

   a_busy_after_work: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.action == dtq_pkg::ACT_QUERY |=> req_stall)
      else $error("Query accepted without the block turning busy.");

endmodule

bind deadline_timer_queue dtq_checker u_dtq_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .req_data(req_data),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data(rsp_data)
);

`default_nettype wire
